// ===== rtl/core/wpf_pkg.sv =====
package wpf_pkg;

  localparam logic [1:0] MODE_CLEAR    = 2'd0;
  localparam logic [1:0] MODE_APPEND   = 2'd1;
  localparam logic [1:0] MODE_CLASSIFY = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic        rule_permit;
    logic [63:0] source_chars;
    logic [63:0] dest_chars;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic       any_match;
    logic [5:0] winning_rule;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic append;
    logic scan_init;
    logic scan_run;
    logic res_none;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_mode;
    logic       count_zero;
    logic       hit;
    logic       last;
    logic       out_free;
  } status_t;

endpackage

// ===== rtl/core/wpf_ctrl.sv =====
module wpf_ctrl
  import wpf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RES  = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (st_i.in_mode)
            MODE_CLEAR:  cmd_o.clear = 1'b1;
            MODE_APPEND: cmd_o.append = 1'b1;
            MODE_CLASSIFY: begin
              cmd_o.capture = 1'b1;
              if (st_i.count_zero) begin
                cmd_o.res_none = 1'b1;
                state_d        = S_RES;
              end else begin
                cmd_o.scan_init = 1'b1;
                state_d         = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (st_i.hit) begin
          state_d = S_RES;
        end else if (st_i.last) begin
          cmd_o.res_none = 1'b1;
          state_d        = S_RES;
        end
      end
      S_RES: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_hit_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && st_i.hit) |=> (state_q == S_RES))
    else $error("scan did not stop on a hit");

  a_scan_needs_rules: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_init |-> !st_i.count_zero)
    else $error("scan started on an empty table");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (st_i.out_free && state_q == S_RES))
    else $error("result loaded into a busy output register");

endmodule

// ===== rtl/core/wpf_datapath.sv =====
module wpf_datapath
  import wpf_pkg::*;
#(
  parameter int MAX_RULES     = 64,
  parameter int PATTERN_CHARS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  cmd_t      cmd_i,
  output status_t   st_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int MEM_W = 129;
  localparam logic [7:0] WILDCARD_CHAR = 8'h3F;

  function automatic logic pattern_match(logic [63:0] pat, logic [63:0] val);
    logic       ok;
    logic       ended;
    logic [7:0] pc;
    logic [7:0] vc;
    ok    = 1'b1;
    ended = 1'b0;
    for (int pos = 0; pos < 8; pos++) begin
      pc = pat[56-8*pos +: 8];
      vc = val[56-8*pos +: 8];
      if (pos < PATTERN_CHARS && !ended) begin
        if (pc == 8'h00) begin
          ended = 1'b1;
        end else if (pc != vc && pc != WILDCARD_CHAR) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  logic [MEM_W-1:0] mem_q [MAX_RULES];
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] addr_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_vld_q;
  logic             rd_permit_q;
  logic [63:0]      rd_src_q;
  logic [63:0]      rd_dst_q;
  logic [63:0]      pkt_src_q;
  logic [63:0]      pkt_dst_q;
  out_word_t        res_q;
  out_word_t        out_q;
  logic             out_valid_q;
  logic             full;
  logic             match;

  assign full  = (count_q >= CNT_W'(MAX_RULES));
  assign match = pattern_match(rd_src_q, pkt_src_q) && pattern_match(rd_dst_q, pkt_dst_q);

  assign st_o.in_mode    = in_word_i.mode;
  assign st_o.count_zero = (count_q == '0);
  assign st_o.hit        = rd_vld_q && match;
  assign st_o.last       = rd_vld_q && (rd_idx_q == '0);
  assign st_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      mem_q[count_q[IDX_W-1:0]] <= {in_word_i.rule_permit, in_word_i.source_chars,
                                    in_word_i.dest_chars};
    end
    if (cmd_i.scan_run) begin
      {rd_permit_q, rd_src_q, rd_dst_q} <= mem_q[addr_q];
      rd_idx_q <= addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pkt_src_q <= in_word_i.source_chars;
      pkt_dst_q <= in_word_i.dest_chars;
    end
    if (cmd_i.scan_init) begin
      addr_q <= IDX_W'(count_q - 1'b1);
    end else if (cmd_i.scan_run && addr_q != '0) begin
      addr_q <= addr_q - 1'b1;
    end
    if (cmd_i.res_none) begin
      res_q <= '0;
    end else if (cmd_i.scan_run && st_o.hit) begin
      res_q.accepted     <= rd_permit_q;
      res_q.any_match    <= 1'b1;
      res_q.winning_rule <= 6'(rd_idx_q);
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.append && !full) begin
        count_q <= count_q + 1'b1;
      end
      rd_vld_q <= cmd_i.scan_run;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RULES))
    else $error("rule count beyond table depth");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (CNT_W'(rd_idx_q) < count_q))
    else $error("scan read above the stored rules");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule

// ===== rtl/core/wildcard_packet_filter_unit.sv =====
// Clear and append words produce no result.
// A classify word is captured and scanned until a rule matches or the oldest rule misses; the result is
// then loaded into the output register once it is free. An empty table skips the scan with no match.
// The single-port rule table reads one rule per cycle, newest first; one word at a time.
// Reset empties the rule table by zeroing the rule count; the table itself is not swept.
// The output register holds the result while the next word is accepted.
module wildcard_packet_filter_unit
  import wpf_pkg::*;
#(
  parameter int MAX_RULES     = 64,
  parameter int PATTERN_CHARS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  cmd_t    cmd;
  status_t st;

  wpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  wpf_datapath #(
    .MAX_RULES     (MAX_RULES),
    .PATTERN_CHARS (PATTERN_CHARS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
